// File: design/pbprc_pkg.sv
package pbprc_pkg;

  // Grid and derived widths
  localparam int CoordBits   = 24;
  localparam int HwBits      = CoordBits - 1;
  localparam int DiffBits    = CoordBits + 1;   // c1 - c2
  localparam int WideBits    = CoordBits + 2;   // doubled diff, wrapped diff, lo
  localparam int MagBits     = CoordBits + 1;   // |d| + wsum
  localparam int SqCapLog    = 26;
  localparam int CapLimBits  = SqCapLog + 1;
  localparam int CapBits     = (MagBits > CapLimBits) ? CapLimBits : MagBits;
  localparam int CapCmpBits  = (MagBits > CapLimBits) ? MagBits : CapLimBits;
  localparam int SqBits      = 2 * CapBits;
  localparam int SumBits     = SqBits + 2;
  localparam int SepBits     = 50;
  localparam int ThrCmpBits  = (SumBits > SepBits) ? SumBits : SepBits;
  localparam int ModeBits    = 3;
  localparam int CfgDataBits = SepBits;
  localparam int CfgIdxBits  = 3;
  localparam int NumAxes     = 3;
  localparam int NumStages   = 6;

  // bin_mode bit positions
  localparam int ModeSpi    = 0;
  localparam int ModeSepMin = 1;
  localparam int ModePiMin  = 2;

  // Axis indexes
  localparam int AxisX = 0;
  localparam int AxisY = 1;
  localparam int AxisZ = 2;

  // Pipeline stage indexes
  localparam int StDiff  = 0;
  localparam int StWrap  = 1;
  localparam int StRange = 2;
  localparam int StSq    = 3;
  localparam int StSum   = 4;
  localparam int StOut   = 5;

  typedef logic [1:0] shift_t;
  localparam shift_t SHIFT_NONE = 2'b00;
  localparam shift_t SHIFT_POS  = 2'b01;
  localparam shift_t SHIFT_NEG  = 2'b11;

  typedef enum logic [1:0] {
    CLS_OUTSIDE   = 2'd0,
    CLS_INSIDE    = 2'd1,
    CLS_INTERSECT = 2'd2,
    CLS_WRAP      = 2'd3
  } pair_class_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BOX_X      = 3'd0,
    REG_BOX_Y      = 3'd1,
    REG_BOX_Z      = 3'd2,
    REG_SEP_SQ_MIN = 3'd3,
    REG_SEP_SQ_MAX = 3'd4,
    REG_PI_MIN     = 3'd5,
    REG_PI_MAX     = 3'd6,
    REG_BIN_MODE   = 3'd7
  } cfg_reg_e;

  // Stage enables from the top-level flow control
  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctrl_t;

  // Range and mode registers seen by the merge stage
  typedef struct packed {
    logic [SepBits-1:0]   sep_sq_min;
    logic [SepBits-1:0]   sep_sq_max;
    logic [CoordBits-1:0] pi_min;
    logic [CoordBits-1:0] pi_max;
    logic [ModeBits-1:0]  bin_mode;
  } range_cfg_t;

  // What one axis lane hands to the merge stage
  typedef struct packed {
    logic [SqBits-1:0]          sq_lo;
    logic [SqBits-1:0]          sq_hi;
    logic signed [WideBits-1:0] lo;
    logic [MagBits-1:0]         hi;
    logic                       wrap;
    shift_t                     shift;
  } lane_res_t;

  // Clamp a distance to 2^26 so its square stays bounded
  function automatic logic [CapBits-1:0] cap_mag(input logic [MagBits-1:0] v);
    logic [CapCmpBits-1:0] v_ext;
    logic [CapCmpBits-1:0] cap;
    v_ext = CapCmpBits'(v);
    cap   = CapCmpBits'(1) << SqCapLog;
    if (v_ext > cap) begin
      return CapBits'(cap);
    end
    return CapBits'(v_ext);
  endfunction

endpackage

// File: design/pbprc_in_if.sv
interface pbprc_in_if;
  logic                                valid;
  logic                                ready;
  logic [pbprc_pkg::CoordBits-1:0]     first_center_x;
  logic [pbprc_pkg::CoordBits-1:0]     first_center_y;
  logic [pbprc_pkg::CoordBits-1:0]     first_center_z;
  logic [pbprc_pkg::HwBits-1:0]        first_half_width_x;
  logic [pbprc_pkg::HwBits-1:0]        first_half_width_y;
  logic [pbprc_pkg::HwBits-1:0]        first_half_width_z;
  logic [pbprc_pkg::CoordBits-1:0]     second_center_x;
  logic [pbprc_pkg::CoordBits-1:0]     second_center_y;
  logic [pbprc_pkg::CoordBits-1:0]     second_center_z;
  logic [pbprc_pkg::HwBits-1:0]        second_half_width_x;
  logic [pbprc_pkg::HwBits-1:0]        second_half_width_y;
  logic [pbprc_pkg::HwBits-1:0]        second_half_width_z;

  modport source (
    output valid, first_center_x, first_center_y, first_center_z,
    output first_half_width_x, first_half_width_y, first_half_width_z,
    output second_center_x, second_center_y, second_center_z,
    output second_half_width_x, second_half_width_y, second_half_width_z,
    input  ready
  );

  modport sink (
    input  valid, first_center_x, first_center_y, first_center_z,
    input  first_half_width_x, first_half_width_y, first_half_width_z,
    input  second_center_x, second_center_y, second_center_z,
    input  second_half_width_x, second_half_width_y, second_half_width_z,
    output ready
  );
endinterface

// File: design/pbprc_out_if.sv
interface pbprc_out_if;
  logic                   valid;
  logic                   ready;
  pbprc_pkg::pair_class_e pair_class;
  logic signed [1:0]      shift_x;
  logic signed [1:0]      shift_y;
  logic signed [1:0]      shift_z;

  modport source (
    output valid, pair_class, shift_x, shift_y, shift_z,
    input  ready
  );

  modport sink (
    input  valid, pair_class, shift_x, shift_y, shift_z,
    output ready
  );
endinterface

// File: design/pbprc_axis_lane.sv
// One axis: periodic wrap of the centre difference, range bounds, squares.
module pbprc_axis_lane (
  input  logic                            clk_i,
  input  pbprc_pkg::pipe_ctrl_t           ctrl_i,
  input  logic [pbprc_pkg::CoordBits-1:0] box_size_i,
  input  logic [pbprc_pkg::CoordBits-1:0] c1_i,
  input  logic [pbprc_pkg::HwBits-1:0]    w1_i,
  input  logic [pbprc_pkg::CoordBits-1:0] c2_i,
  input  logic [pbprc_pkg::HwBits-1:0]    w2_i,
  output pbprc_pkg::lane_res_t            res_o
);
  import pbprc_pkg::*;

  logic signed [DiffBits-1:0] diff_d, diff_q;
  logic [CoordBits-1:0]       wsum_d, wsum_q, wsum2_q;
  logic signed [WideBits-1:0] twice_d, box_s, diff_ext;
  logic signed [WideBits-1:0] wd_d, wd_q;
  shift_t                     shift_d, shift_q, shift3_q;
  logic signed [WideBits-1:0] abs_w;
  logic [MagBits-1:0]         dist_mag;
  logic signed [WideBits-1:0] lo_d, lo_q;
  logic [MagBits-1:0]         hi_d, hi_q;
  logic [MagBits-1:0]         pos_lo;
  logic [CapBits-1:0]         cap_lo, cap_hi;
  lane_res_t                  res_d, res_q;

  // Stage 1: centre difference and half-width sum
  assign diff_d = $signed({1'b0, c1_i}) - $signed({1'b0, c2_i});
  assign wsum_d = {1'b0, w1_i} + {1'b0, w2_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[StDiff]) begin
      diff_q <= diff_d;
      wsum_q <= wsum_d;
    end
  end

  // Stage 2: wrap across half the box, tests in doubled units
  assign twice_d  = {diff_q, 1'b0};
  assign box_s    = $signed({2'b00, box_size_i});
  assign diff_ext = {diff_q[DiffBits-1], diff_q};

  always_comb begin
    wd_d    = diff_ext;
    shift_d = SHIFT_NONE;
    if (twice_d > box_s) begin
      wd_d    = diff_ext - box_s;
      shift_d = SHIFT_NEG;
    end else if (twice_d < -box_s) begin
      wd_d    = diff_ext + box_s;
      shift_d = SHIFT_POS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[StWrap]) begin
      wd_q    <= wd_d;
      shift_q <= shift_d;
      wsum2_q <= wsum_q;
    end
  end

  // Stage 3: distance and its near and far bounds
  assign abs_w    = wd_q[WideBits-1] ? -wd_q : wd_q;
  assign dist_mag = abs_w[MagBits-1:0];
  assign lo_d     = $signed({1'b0, dist_mag}) - $signed({2'b00, wsum2_q});
  assign hi_d     = dist_mag + {1'b0, wsum2_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[StRange]) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      shift3_q <= shift_q;
    end
  end

  // Stage 4: clamped squares and the wrap-check flag
  assign pos_lo = (lo_q > 0) ? lo_q[MagBits-1:0] : '0;
  assign cap_lo = cap_mag(pos_lo);
  assign cap_hi = cap_mag(hi_q);

  always_comb begin
    res_d.sq_lo = SqBits'(cap_lo) * SqBits'(cap_lo);
    res_d.sq_hi = SqBits'(cap_hi) * SqBits'(cap_hi);
    res_d.lo    = lo_q;
    res_d.hi    = hi_q;
    res_d.wrap  = {1'b0, hi_q, 1'b0} >= {3'b000, box_size_i};
    res_d.shift = shift3_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[StSq]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule

// File: design/pbprc_merge.sv
// Combines the three lanes: squared sums, range tests, classification.
module pbprc_merge (
  input  logic                   clk_i,
  input  pbprc_pkg::pipe_ctrl_t  ctrl_i,
  input  pbprc_pkg::range_cfg_t  cfg_i,
  input  pbprc_pkg::lane_res_t   lane_i [pbprc_pkg::NumAxes],
  output pbprc_pkg::pair_class_e pair_class_o,
  output pbprc_pkg::shift_t      shift_o [pbprc_pkg::NumAxes]
);
  import pbprc_pkg::*;

  logic                      spi, pmin_on;
  logic [SumBits-1:0]        smin_d, smin_q, smax_d, smax_q;
  logic [SqBits-1:0]         z_lo, z_hi;
  logic                      pi_early_d, pi_early_q, pi_ok_d, pi_ok_q;
  logic                      wrap_d, wrap_q;
  logic signed [WideBits-1:0] pi_min_s, pi_max_s;
  shift_t                    shift_q [NumAxes];
  logic [ThrCmpBits-1:0]     smin_e, smax_e, thr_min, thr_max;
  logic                      ge_smin_max, lt_smax_min, ge_smin_min, lt_smax_max;
  pair_class_e               straddle, cls_d, cls_q;
  shift_t                    shift_out_q [NumAxes];

  assign spi     = cfg_i.bin_mode[ModeSpi];
  assign pmin_on = cfg_i.bin_mode[ModePiMin];

  // Stage 5: sums of squares (z left out in s-pi mode) and pi tests
  assign z_lo = spi ? '0 : lane_i[AxisZ].sq_lo;
  assign z_hi = spi ? '0 : lane_i[AxisZ].sq_hi;
  assign smin_d = SumBits'(lane_i[AxisX].sq_lo) + SumBits'(lane_i[AxisY].sq_lo)
                + SumBits'(z_lo);
  assign smax_d = SumBits'(lane_i[AxisX].sq_hi) + SumBits'(lane_i[AxisY].sq_hi)
                + SumBits'(z_hi);

  assign pi_min_s = $signed({2'b00, cfg_i.pi_min});
  assign pi_max_s = $signed({2'b00, cfg_i.pi_max});

  always_comb begin
    pi_early_d = spi && ((lane_i[AxisZ].lo >= pi_max_s) ||
                         (pmin_on && (lane_i[AxisZ].hi < {1'b0, cfg_i.pi_min})));
    pi_ok_d    = !spi || ((!pmin_on || (lane_i[AxisZ].lo >= pi_min_s)) &&
                          (lane_i[AxisZ].hi < {1'b0, cfg_i.pi_max}));
    wrap_d     = lane_i[AxisX].wrap || lane_i[AxisY].wrap || lane_i[AxisZ].wrap;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[StSum]) begin
      smin_q     <= smin_d;
      smax_q     <= smax_d;
      pi_early_q <= pi_early_d;
      pi_ok_q    <= pi_ok_d;
      wrap_q     <= wrap_d;
      for (int a = 0; a < NumAxes; a++) begin
        shift_q[a] <= lane_i[a].shift;
      end
    end
  end

  // Stage 6: threshold compares and class decision
  assign smin_e  = ThrCmpBits'(smin_q);
  assign smax_e  = ThrCmpBits'(smax_q);
  assign thr_min = ThrCmpBits'(cfg_i.sep_sq_min);
  assign thr_max = ThrCmpBits'(cfg_i.sep_sq_max);

  assign ge_smin_max = smin_e >= thr_max;
  assign lt_smax_min = smax_e < thr_min;
  assign ge_smin_min = smin_e >= thr_min;
  assign lt_smax_max = smax_e < thr_max;
  assign straddle    = wrap_q ? CLS_WRAP : CLS_INTERSECT;

  always_comb begin
    priority if (pi_early_q || ge_smin_max) begin
      cls_d = CLS_OUTSIDE;
    end else if (cfg_i.bin_mode[ModeSepMin]) begin
      priority if (lt_smax_min) begin
        cls_d = CLS_OUTSIDE;
      end else if (ge_smin_min && lt_smax_max && pi_ok_q) begin
        cls_d = CLS_INSIDE;
      end else begin
        cls_d = straddle;
      end
    end else if (lt_smax_max && pi_ok_q) begin
      cls_d = CLS_INSIDE;
    end else begin
      cls_d = straddle;
    end
  end

  // Output register holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[StOut]) begin
      cls_q <= cls_d;
      for (int a = 0; a < NumAxes; a++) begin
        shift_out_q[a] <= shift_q[a];
      end
    end
  end

  assign pair_class_o = cls_q;
  assign shift_o      = shift_out_q;
endmodule

// File: design/periodic_box_pair_range_classifier_unit.sv
// Periodic box-pair range classifier.
// in_chan carries one box pair per item (centres and half-widths per axis);
// out_chan returns one item per pair: pair_class and the x/y/z wrap shifts.
// Both channels use valid/ready; an item moves when both are high.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i),
// to be written only while the block holds no item; the block does not enforce it.
// Three axis lanes run side by side for four stages (difference, wrap,
// bounds, squares); a merge unit sums, tests ranges and classifies in two.
// Six register stages lie between input and output; the output register is
// the last of them, and out_chan.valid is its valid bit.
// Throughput: one item per cycle while the receiver does not stall.
// Each stage has its own valid bit and advances when empty or when the next
// stage advances, so bubbles close up and input is taken while a finished
// item waits in the output register. When the receiver stalls, the output
// register holds its item; once all six stages hold an item the input side
// stalls too.
// Reset empties the pipeline and loads the default box sizes and ranges.
module periodic_box_pair_range_classifier_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pbprc_in_if.sink                          in_chan,
  pbprc_out_if.source                       out_chan,
  input  logic                              cfg_we_i,
  input  logic [pbprc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [pbprc_pkg::CfgDataBits-1:0] cfg_data_i
);
  import pbprc_pkg::*;

  logic [CoordBits-1:0]  box_q [NumAxes];
  range_cfg_t            cfg_q;
  logic [NumStages-1:0]  vld_d, vld_q, en;
  pipe_ctrl_t            ctrl;
  lane_res_t             lane_res [NumAxes];
  logic [CoordBits-1:0]  c1 [NumAxes];
  logic [CoordBits-1:0]  c2 [NumAxes];
  logic [HwBits-1:0]     w1 [NumAxes];
  logic [HwBits-1:0]     w2 [NumAxes];
  shift_t                shift [NumAxes];
  pair_class_e           pair_class;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        box_q[a] <= '1;
      end
      cfg_q.sep_sq_min <= '0;
      cfg_q.sep_sq_max <= '1;
      cfg_q.pi_min     <= '0;
      cfg_q.pi_max     <= '1;
      cfg_q.bin_mode   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_X:      box_q[AxisX]     <= cfg_data_i[CoordBits-1:0];
        REG_BOX_Y:      box_q[AxisY]     <= cfg_data_i[CoordBits-1:0];
        REG_BOX_Z:      box_q[AxisZ]     <= cfg_data_i[CoordBits-1:0];
        REG_SEP_SQ_MIN: cfg_q.sep_sq_min <= cfg_data_i[SepBits-1:0];
        REG_SEP_SQ_MAX: cfg_q.sep_sq_max <= cfg_data_i[SepBits-1:0];
        REG_PI_MIN:     cfg_q.pi_min     <= cfg_data_i[CoordBits-1:0];
        REG_PI_MAX:     cfg_q.pi_max     <= cfg_data_i[CoordBits-1:0];
        REG_BIN_MODE:   cfg_q.bin_mode   <= cfg_data_i[ModeBits-1:0];
        default:        ;
      endcase
    end
  end

  // Per-stage flow control: a stage loads when empty or draining
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_chan.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_chan.valid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl.en       = en;
  assign in_chan.ready = en[0];

  // Lane inputs by axis
  assign c1[AxisX] = in_chan.first_center_x;
  assign c1[AxisY] = in_chan.first_center_y;
  assign c1[AxisZ] = in_chan.first_center_z;
  assign w1[AxisX] = in_chan.first_half_width_x;
  assign w1[AxisY] = in_chan.first_half_width_y;
  assign w1[AxisZ] = in_chan.first_half_width_z;
  assign c2[AxisX] = in_chan.second_center_x;
  assign c2[AxisY] = in_chan.second_center_y;
  assign c2[AxisZ] = in_chan.second_center_z;
  assign w2[AxisX] = in_chan.second_half_width_x;
  assign w2[AxisY] = in_chan.second_half_width_y;
  assign w2[AxisZ] = in_chan.second_half_width_z;

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    pbprc_axis_lane u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .box_size_i (box_q[a]),
      .c1_i       (c1[a]),
      .w1_i       (w1[a]),
      .c2_i       (c2[a]),
      .w2_i       (w2[a]),
      .res_o      (lane_res[a])
    );
  end

  pbprc_merge u_merge (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg_q),
    .lane_i       (lane_res),
    .pair_class_o (pair_class),
    .shift_o      (shift)
  );

  assign out_chan.valid      = vld_q[NumStages-1];
  assign out_chan.pair_class = pair_class;
  assign out_chan.shift_x    = shift[AxisX];
  assign out_chan.shift_y    = shift[AxisY];
  assign out_chan.shift_z    = shift[AxisZ];

  // Input side only stalls with every stage full and the output blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_chan.ready |-> (&vld_q && !out_chan.ready))
    else $error("input stalled with room in the pipeline");

  // Items in flight change only by accepts and deliveries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(vld_q) + ($past(out_chan.valid && out_chan.ready) ? 1 : 0) ==
       $past($countones(vld_q)) + ($past(in_chan.valid && in_chan.ready) ? 1 : 0)))
    else $error("item lost or duplicated in the pipeline");

  // Delivered shifts are always -1, 0 or +1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid |->
      ((shift[AxisX] == SHIFT_NONE || shift[AxisX] == SHIFT_POS ||
        shift[AxisX] == SHIFT_NEG) &&
       (shift[AxisY] == SHIFT_NONE || shift[AxisY] == SHIFT_POS ||
        shift[AxisY] == SHIFT_NEG) &&
       (shift[AxisZ] == SHIFT_NONE || shift[AxisZ] == SHIFT_POS ||
        shift[AxisZ] == SHIFT_NEG)))
    else $error("illegal wrap shift code");
endmodule

// File: bench/periodic_box_pair_range_classifier_unit_test.sv
`timescale 1ns / 100ps

module periodic_box_pair_range_classifier_unit_test;
  import pbprc_pkg::*;

  localparam logic [CoordBits-1:0] CMax    = {CoordBits{1'b1}};
  localparam logic [CoordBits-1:0] CHalf   = CoordBits'(1) << (CoordBits - 1);
  localparam logic [HwBits-1:0]    HwMax   = {HwBits{1'b1}};
  localparam logic [SepBits-1:0]   SepAll  = {SepBits{1'b1}};
  localparam longint               SqLimit = longint'(1) << SqCapLog;
  localparam int                   RandPhases = 10;
  localparam int                   PairsPerPhase = 135;

  // One box pair, index 0 is the x axis
  typedef struct packed {
    logic [NumAxes-1:0][CoordBits-1:0] ctr_a;
    logic [NumAxes-1:0][HwBits-1:0]    hw_a;
    logic [NumAxes-1:0][CoordBits-1:0] ctr_b;
    logic [NumAxes-1:0][HwBits-1:0]    hw_b;
  } box_pair_t;

  typedef struct packed {
    pair_class_e            cls;
    shift_t [NumAxes-1:0]   shift;
  } pair_verdict_t;

  typedef struct packed {
    logic [NumAxes-1:0][CoordBits-1:0] box;
    logic [SepBits-1:0]                sep_min;
    logic [SepBits-1:0]                sep_max;
    logic [CoordBits-1:0]              pi_min;
    logic [CoordBits-1:0]              pi_max;
    logic [ModeBits-1:0]               mode;
  } setting_t;

  // Holds a copy of the registers, classifies each accepted pair and
  // matches the verdicts coming out of the block in order.
  class pair_verdict_board;
    logic [NumAxes-1:0][CoordBits-1:0] box_len;
    logic [SepBits-1:0]                sep_lo_sq;
    logic [SepBits-1:0]                sep_hi_sq;
    logic [CoordBits-1:0]              los_lo;
    logic [CoordBits-1:0]              los_hi;
    logic [ModeBits-1:0]               mode;
    pair_verdict_t                     awaited[$];
    int                                errors;
    int                                pairs;
    int                                shifted;
    int                                hits[4];

    function new();
      box_len   = '1;
      sep_lo_sq = '0;
      sep_hi_sq = '1;
      los_lo    = '0;
      los_hi    = '1;
      mode      = '0;
      errors    = 0;
      pairs     = 0;
      shifted   = 0;
      foreach (hits[i]) hits[i] = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataBits-1:0] val);
      case (idx)
        REG_BOX_X:      box_len[AxisX] = val[CoordBits-1:0];
        REG_BOX_Y:      box_len[AxisY] = val[CoordBits-1:0];
        REG_BOX_Z:      box_len[AxisZ] = val[CoordBits-1:0];
        REG_SEP_SQ_MIN: sep_lo_sq = val[SepBits-1:0];
        REG_SEP_SQ_MAX: sep_hi_sq = val[SepBits-1:0];
        REG_PI_MIN:     los_lo = val[CoordBits-1:0];
        REG_PI_MAX:     los_hi = val[CoordBits-1:0];
        REG_BIN_MODE:   mode = val[ModeBits-1:0];
        default: ;
      endcase
    endfunction

    // Distance clamped to 2^26 before squaring
    function longint cap_sq(longint v);
      if (v < 0) v = -v;
      if (v > SqLimit) v = SqLimit;
      return v * v;
    endfunction

    function longint gap_sq(longint v);
      return (v > 0) ? cap_sq(v) : 0;
    endfunction

    function pair_verdict_t classify_pair(box_pair_t p);
      pair_verdict_t v;
      longint        b, d, wsum;
      longint        span_lo[NumAxes];
      longint        span_hi[NumAxes];
      longint        smin, smax, qmin, qmax, plo, phi;
      logic          near_edge, pmin_on, pi_ok;
      near_edge = 1'b0;
      // per axis: periodic wrap once, then bounds of the separation
      for (int a = 0; a < NumAxes; a++) begin
        b = longint'(box_len[a]);
        d = longint'(p.ctr_a[a]) - longint'(p.ctr_b[a]);
        v.shift[a] = SHIFT_NONE;
        if (2 * d > b) begin
          d = d - b;
          v.shift[a] = SHIFT_NEG;
        end else if (2 * d < -b) begin
          d = d + b;
          v.shift[a] = SHIFT_POS;
        end
        if (d < 0) d = -d;
        wsum = longint'(p.hw_a[a]) + longint'(p.hw_b[a]);
        span_lo[a] = d - wsum;
        span_hi[a] = d + wsum;
        if (2 * span_hi[a] >= b) near_edge = 1'b1;
      end
      qmin = longint'(sep_lo_sq);
      qmax = longint'(sep_hi_sq);
      plo  = longint'(los_lo);
      phi  = longint'(los_hi);
      if (!mode[ModeSpi]) begin
        // isotropic: all three axes in the separation
        smin = gap_sq(span_lo[AxisX]) + gap_sq(span_lo[AxisY]) + gap_sq(span_lo[AxisZ]);
        smax = cap_sq(span_hi[AxisX]) + cap_sq(span_hi[AxisY]) + cap_sq(span_hi[AxisZ]);
        if (smin >= qmax) begin
          v.cls = CLS_OUTSIDE;
        end else if (mode[ModeSepMin]) begin
          if (smax < qmin) v.cls = CLS_OUTSIDE;
          else if (smin >= qmin && smax < qmax) v.cls = CLS_INSIDE;
          else v.cls = near_edge ? CLS_WRAP : CLS_INTERSECT;
        end else if (smax < qmax) begin
          v.cls = CLS_INSIDE;
        end else begin
          v.cls = near_edge ? CLS_WRAP : CLS_INTERSECT;
        end
      end else begin
        // s-perp from x and y, line of sight along z
        pmin_on = mode[ModePiMin];
        smin  = gap_sq(span_lo[AxisX]) + gap_sq(span_lo[AxisY]);
        smax  = cap_sq(span_hi[AxisX]) + cap_sq(span_hi[AxisY]);
        pi_ok = (!pmin_on || span_lo[AxisZ] >= plo) && span_hi[AxisZ] < phi;
        if (span_lo[AxisZ] >= phi) begin
          v.cls = CLS_OUTSIDE;
        end else if (pmin_on && span_hi[AxisZ] < plo) begin
          v.cls = CLS_OUTSIDE;
        end else if (smin >= qmax) begin
          v.cls = CLS_OUTSIDE;
        end else if (mode[ModeSepMin]) begin
          if (smax < qmin) v.cls = CLS_OUTSIDE;
          else if (smin >= qmin && smax < qmax && pi_ok) v.cls = CLS_INSIDE;
          else v.cls = near_edge ? CLS_WRAP : CLS_INTERSECT;
        end else if (smax < qmax && pi_ok) begin
          v.cls = CLS_INSIDE;
        end else begin
          v.cls = near_edge ? CLS_WRAP : CLS_INTERSECT;
        end
      end
      return v;
    endfunction

    function void note_pair(box_pair_t p);
      awaited.push_back(classify_pair(p));
      pairs++;
    endfunction

    function void check_verdict(pair_class_e cls, logic [1:0] sx, logic [1:0] sy,
                                logic [1:0] sz);
      pair_verdict_t       want;
      shift_t [NumAxes-1:0] got;
      string               axis_tag;
      axis_tag = "xyz";
      got = {sz, sy, sx};
      if (awaited.size() == 0) begin
        $error("unexpected result item: pair_class %0d", cls);
        errors++;
        return;
      end
      want = awaited.pop_front();
      hits[want.cls]++;
      if (want.shift != '0) shifted++;
      if (cls !== want.cls) begin
        $error("pair_class: expected %0d, got %0d", want.cls, cls);
        errors++;
      end
      for (int a = 0; a < NumAxes; a++) begin
        if (got[a] !== want.shift[a]) begin
          $error("shift_%c: expected %0d, got %0d", axis_tag[a],
                 $signed(want.shift[a]), $signed(got[a]));
          errors++;
        end
      end
    endfunction

    function void flush_left();
      foreach (awaited[i]) begin
        $error("pair_class: expected %0d, no result item came", awaited[i].cls);
        errors++;
      end
      awaited.delete();
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  int                     gap_pct;
  int                     stall_pct;
  int                     n_settings;
  pair_verdict_board      board;

  pbprc_in_if  in_chan ();
  pbprc_out_if out_chan ();

  periodic_box_pair_range_classifier_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Put a pair on the input channel
  task automatic present_pair(box_pair_t p);
    in_chan.first_center_x      = p.ctr_a[AxisX];
    in_chan.first_center_y      = p.ctr_a[AxisY];
    in_chan.first_center_z      = p.ctr_a[AxisZ];
    in_chan.first_half_width_x  = p.hw_a[AxisX];
    in_chan.first_half_width_y  = p.hw_a[AxisY];
    in_chan.first_half_width_z  = p.hw_a[AxisZ];
    in_chan.second_center_x     = p.ctr_b[AxisX];
    in_chan.second_center_y     = p.ctr_b[AxisY];
    in_chan.second_center_z     = p.ctr_b[AxisZ];
    in_chan.second_half_width_x = p.hw_b[AxisX];
    in_chan.second_half_width_y = p.hw_b[AxisY];
    in_chan.second_half_width_z = p.hw_b[AxisZ];
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_pair(box_pair_t p);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    present_pair(p);
    in_chan.valid = 1'b1;
    do begin
      @(posedge clk_i);
    end while (in_chan.ready !== 1'b1);
    board.note_pair(p);
    @(negedge clk_i);
  endtask

  // Hold the input off until every verdict is back, then let the pipe settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_chan.valid = 1'b0;
    while (board.outstanding() != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic load_reg(cfg_reg_e idx, logic [CfgDataBits-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    board.set_reg(idx, val);
  endtask

  task automatic apply_setting(setting_t s);
    load_reg(REG_BOX_X, CfgDataBits'(s.box[AxisX]));
    load_reg(REG_BOX_Y, CfgDataBits'(s.box[AxisY]));
    load_reg(REG_BOX_Z, CfgDataBits'(s.box[AxisZ]));
    load_reg(REG_SEP_SQ_MIN, CfgDataBits'(s.sep_min));
    load_reg(REG_SEP_SQ_MAX, CfgDataBits'(s.sep_max));
    load_reg(REG_PI_MIN, CfgDataBits'(s.pi_min));
    load_reg(REG_PI_MAX, CfgDataBits'(s.pi_max));
    load_reg(REG_BIN_MODE, CfgDataBits'(s.mode));
    cfg_we_i = 1'b0;
    n_settings++;
  endtask

  function automatic setting_t make_setting(logic [CoordBits-1:0] bx, logic [CoordBits-1:0] by,
                                            logic [CoordBits-1:0] bz, logic [SepBits-1:0] smin,
                                            logic [SepBits-1:0] smax, logic [CoordBits-1:0] pmin,
                                            logic [CoordBits-1:0] pmax, logic [ModeBits-1:0] md);
    setting_t s;
    s.box[AxisX] = bx;
    s.box[AxisY] = by;
    s.box[AxisZ] = bz;
    s.sep_min    = smin;
    s.sep_max    = smax;
    s.pi_min     = pmin;
    s.pi_max     = pmax;
    s.mode       = md;
    return s;
  endfunction

  function automatic box_pair_t uniform_pair(logic [CoordBits-1:0] ca, logic [HwBits-1:0] wa,
                                             logic [CoordBits-1:0] cb, logic [HwBits-1:0] wb);
    box_pair_t p;
    for (int a = 0; a < NumAxes; a++) begin
      p.ctr_a[a] = ca;
      p.hw_a[a]  = wa;
      p.ctr_b[a] = cb;
      p.hw_b[a]  = wb;
    end
    return p;
  endfunction

  // Thresholds sized around 2^k so that all verdicts show up
  function automatic setting_t random_setting(int ph, int k);
    setting_t s;
    longint   span, bx, pm;
    span = longint'(1) << k;
    for (int a = 0; a < NumAxes; a++) begin
      case ($urandom_range(0, 3))
        0:       bx = 64'hFFFFFF;
        1:       bx = longint'($urandom_range(1, 24'hFFFFFF));
        2:       bx = (span << $urandom_range(0, 2)) + longint'($urandom_range(0, 7));
        default: bx = longint'($urandom_range(1, 32'(span)));
      endcase
      if (bx > 64'hFFFFFF) bx = 64'hFFFFFF;
      s.box[a] = CoordBits'(bx);
    end
    s.sep_max = SepBits'(span * span * longint'($urandom_range(1, 6)));
    s.sep_min = SepBits'(span * span / longint'($urandom_range(2, 16)));
    pm = span * longint'($urandom_range(1, 4)) / 2;
    if (pm > 64'hFFFFFF) pm = 64'hFFFFFF;
    s.pi_max = CoordBits'(pm);
    s.pi_min = CoordBits'(span / longint'($urandom_range(2, 8)));
    if ($urandom_range(0, 5) == 0) s.sep_max = SepAll;
    if ($urandom_range(0, 5) == 0) s.sep_min = '0;
    s.mode = ModeBits'(ph);
    return s;
  endfunction

  // Mostly nearby boxes at the phase scale, some wrapped by a box length,
  // the rest fully random fields or field extremes
  function automatic box_pair_t random_pair(setting_t s, int k);
    box_pair_t p;
    longint    span, delta, bx;
    int        pick;
    span = longint'(1) << k;
    pick = $urandom_range(0, 19);
    for (int a = 0; a < NumAxes; a++) begin
      bx = longint'(s.box[a]);
      if (pick < 2) begin
        p.ctr_a[a] = CoordBits'($urandom);
        p.ctr_b[a] = CoordBits'($urandom);
        p.hw_a[a]  = HwBits'($urandom);
        p.hw_b[a]  = HwBits'($urandom);
      end else if (pick == 2) begin
        p.ctr_a[a] = $urandom_range(0, 1) ? CMax : '0;
        p.ctr_b[a] = $urandom_range(0, 1) ? CMax : '0;
        p.hw_a[a]  = $urandom_range(0, 1) ? HwMax : '0;
        p.hw_b[a]  = $urandom_range(0, 1) ? HwMax : '0;
      end else begin
        if ($urandom_range(0, 1) == 1) p.ctr_a[a] = CoordBits'($urandom_range(0, 32'(bx)));
        else p.ctr_a[a] = CoordBits'($urandom);
        delta = longint'($urandom_range(0, 32'(2 * span))) - span;
        if ($urandom_range(0, 3) == 0) delta = ($urandom_range(0, 1) == 1) ? delta + bx
                                                                         : delta - bx;
        p.ctr_b[a] = CoordBits'(longint'(p.ctr_a[a]) - delta);
        p.hw_a[a]  = HwBits'($urandom_range(0, 32'(span / 2)));
        p.hw_b[a]  = HwBits'($urandom_range(0, 32'(span / 2)));
      end
    end
    return p;
  endfunction

  // Result side: random stall bursts that hold out_chan.ready low
  initial begin
    int hold;
    hold = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        out_chan.ready = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 17) - 1;
        out_chan.ready = 1'b0;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      board.check_verdict(out_chan.pair_class, out_chan.shift_x, out_chan.shift_y,
                          out_chan.shift_z);
    end
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // Main sequence
  initial begin
    box_pair_t p;
    setting_t  s;
    int        k;
    board      = new();
    gap_pct    = 0;
    stall_pct  = 0;
    n_settings = 0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_BOX_X;
    cfg_data_i = '0;
    in_chan.valid = 1'b0;
    present_pair(uniform_pair('0, '0, '0, '0));
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // open range, full boxes: field extremes and the half-box boundary
    apply_setting(make_setting(CMax, CMax, CMax, '0, SepAll, '0, CMax, 3'b000));
    gap_pct   = 20;
    stall_pct = 20;
    send_pair(uniform_pair('0, '0, '0, '0));
    send_pair(uniform_pair(CMax, HwMax, CMax, HwMax));
    send_pair(uniform_pair(CMax, '0, '0, '0));
    send_pair(uniform_pair('0, '0, CMax, '0));
    send_pair(uniform_pair(CHalf, '0, '0, '0));
    send_pair(uniform_pair(CHalf - 1'b1, '0, '0, '0));
    send_pair(uniform_pair('0, '0, CHalf, '0));
    p = uniform_pair('0, HwMax, '0, '0);
    p.ctr_a[AxisX] = CMax;
    p.ctr_b[AxisY] = CMax;
    p.hw_b[AxisZ]  = HwMax;
    send_pair(p);
    wait_idle();

    // small boxes, centres beyond the box, pi-minimum bit set in isotropic mode
    apply_setting(make_setting(24'd1000, 24'd1001, 24'd2, 50'd100, 50'd10000, 24'd5, 24'd50,
                               3'b110));
    send_pair(uniform_pair(24'd5000, '0, 24'd10, '0));
    send_pair(uniform_pair(24'd100, 23'd1, 24'd100, 23'd1));
    send_pair(uniform_pair(24'd110, '0, 24'd100, '0));
    send_pair(uniform_pair(24'd110, 23'd20, 24'd100, 23'd20));
    send_pair(uniform_pair(24'd9000, 23'd3, '0, 23'd3));
    wait_idle();

    // zero box length on x, s-pi binning with both minima
    apply_setting(make_setting('0, 24'd100, CMax, 50'd50, 50'd5000, 24'd20, 24'd200,
                               3'b111));
    p = uniform_pair('0, '0, '0, '0);
    p.ctr_a[AxisX] = 24'd7;
    p.ctr_a[AxisY] = 24'd5;
    p.ctr_a[AxisZ] = 24'd50;
    send_pair(p);
    p = uniform_pair('0, '0, '0, '0);
    p.ctr_a[AxisZ] = 24'd300;
    send_pair(p);
    p.ctr_a[AxisZ] = 24'd5;
    send_pair(p);
    send_pair(uniform_pair(24'd3, 23'd40, '0, 23'd40));
    wait_idle();

    // inverted extremes of every range register
    apply_setting(make_setting(24'd1, 24'd1, 24'd1, SepAll, '0, CMax, '0, 3'b001));
    send_pair(uniform_pair(CMax, HwMax, '0, HwMax));
    send_pair(uniform_pair('0, '0, '0, '0));
    send_pair(uniform_pair(24'd1, '0, '0, '0));
    wait_idle();

    apply_setting(make_setting(CMax, CMax, CMax, SepAll, SepAll, '0, CMax, 3'b010));
    send_pair(uniform_pair('0, '0, '0, '0));
    send_pair(uniform_pair(CMax, HwMax, CMax, HwMax));
    send_pair(uniform_pair(CHalf, HwMax, '0, '0));
    wait_idle();

    // random phases, one per bin mode and more; the last runs without input gaps or output stalls
    for (int ph = 0; ph < RandPhases; ph++) begin
      k = $urandom_range(3, 22);
      s = random_setting(ph, k);
      apply_setting(s);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 40;
      endcase
      if (ph == RandPhases - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      for (int n = 0; n < PairsPerPhase; n++) begin
        if (ph == 4 && n == PairsPerPhase / 2) wait_idle();
        send_pair(random_pair(s, k));
      end
      wait_idle();
    end

    board.flush_left();
    $display("%0d box pairs checked over %0d register settings covering all bin modes",
             board.pairs, n_settings);
    $display("outside %0d, inside %0d, intersect %0d, wrap check %0d; %0d with a wrap shift",
             board.hits[CLS_OUTSIDE], board.hits[CLS_INSIDE], board.hits[CLS_INTERSECT],
             board.hits[CLS_WRAP], board.shifted);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
